// File: rtl/xarr_pkg.sv
// ----------------------------------------------------------------------------
// xarr_pkg
// Shared constants and helpers for the audio ring resampler and mixer.
// ----------------------------------------------------------------------------
package xarr_pkg;

    localparam int RING_DEPTH    = 16384;
    localparam int FRAME_SAMPLES = 32;
    localparam int IDX_W         = $clog2(RING_DEPTH);
    localparam int FRAME_W       = $clog2(FRAME_SAMPLES + 1);

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 20;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic [15:0] OUT_RATE     = 16'd44100;
    localparam logic [31:0] PHASE_ONE    = 32'h0001_0000;
    localparam logic [6:0]  REPEAT_START = 7'd100;
    localparam logic [19:0] LEN_MAX      = 20'hF_FFFF;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_MIX    = 2'd2;

    localparam logic [1:0] REG_ENABLE       = 2'd0;
    localparam logic [1:0] REG_LEFT_VOLUME  = 2'd1;
    localparam logic [1:0] REG_RIGHT_VOLUME = 2'd2;

    function automatic logic [15:0] scale_half(input logic [15:0] half,
                                               input logic [14:0] vol);
        logic signed [31:0] prod;
        logic signed [31:0] adj;
        prod = 32'($signed(half)) * 32'($signed({1'b0, vol}));
        adj  = prod + ((prod < 0) ? 32'sd32767 : 32'sd0);
        return 16'(adj >>> 15);
    endfunction

endpackage

// File: rtl/xarr_div.sv
// ----------------------------------------------------------------------------
// xarr_div
// Restoring divider, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module xarr_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [xarr_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [xarr_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           done,
    output logic [xarr_pkg::DIVIDEND_W-1:0] quotient
);
    import xarr_pkg::*;

    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/xa_audio_ring_resample_mix_core.sv
// ----------------------------------------------------------------------------
// xa_audio_ring_resample_mix_core
// Start: two passes of the shared divider, for the block length and then the phase step.
// Sample: writes ring words one per cycle (one ring write port).
// Mix: 32 results, each through select, ring read (for ring words), emit and hold; m_ready can stall the hold.
// One item at a time; s_ready is high only when idle.
// Reset clears control state and indexes; ring contents stay undefined.
// ----------------------------------------------------------------------------
module xa_audio_ring_resample_mix_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [11:0] s_block_samples,
    input  logic [15:0] s_source_rate,
    input  logic        s_stereo,
    input  logic signed [15:0] s_left_sample,
    input  logic signed [15:0] s_right_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_left_add,
    output logic signed [15:0] m_right_add,
    output logic        m_last
);
    import xarr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVL  = 3'd1;
    localparam logic [2:0] ST_DIVS  = 3'd2;
    localparam logic [2:0] ST_WR    = 3'd3;
    localparam logic [2:0] ST_MSEL  = 3'd4;
    localparam logic [2:0] ST_MRD   = 3'd5;
    localparam logic [2:0] ST_MEMIT = 3'd6;
    localparam logic [2:0] ST_MHOLD = 3'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    logic [31:0] ring [RING_DEPTH];
    logic [31:0] rdata_reg;
    logic        ring_we;
    logic        ring_re;

    logic [2:0]       state_reg, state_next;
    logic             enable_reg, enable_next;
    logic [14:0]      lvol_reg, lvol_next;
    logic [14:0]      rvol_reg, rvol_next;
    logic [IDX_W-1:0] wr_reg, wr_next;
    logic [IDX_W-1:0] rd_reg, rd_next;
    logic [6:0]       rep_reg, rep_next;
    logic [31:0]      phase_reg, phase_next;
    logic [31:0]      step_reg, step_next;
    logic [19:0]      left_reg, left_next;
    logic             active_reg, active_next;
    logic             mono_reg, mono_next;
    logic             stereo_reg, stereo_next;
    logic [11:0]      samples_reg, samples_next;
    logic [19:0]      len_reg, len_next;
    logic [31:0]      word_reg, word_next;
    logic [31:0]      lastval_reg, lastval_next;
    logic [FRAME_W-1:0] pos_reg, pos_next;
    logic             reading_reg, reading_next;
    logic             fill_rep_reg, fill_rep_next;
    logic             mv_reg, mv_next;
    logic [15:0]      ml_reg, ml_next;
    logic [15:0]      mr_reg, mr_next;
    logic             mlast_reg, mlast_next;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_q;
    logic [19:0]           len_sat;
    logic [IDX_W-1:0]      wr_inc;
    logic [19:0]           left_dec;
    logic                  s_acc;

    xarr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign len_sat  = (div_q > 32'(LEN_MAX)) ? LEN_MAX : div_q[19:0];
    assign wr_inc   = (wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1;
    assign left_dec = left_reg - 1'b1;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = 32'(OUT_RATE) * 32'(s_block_samples);
        div_divisor  = 20'(s_source_rate);
        if (state_reg == ST_DIVL) begin
            div_dividend = {4'b0, samples_reg, 16'b0};
            div_divisor  = len_sat;
            div_start    = div_done && (len_sat != '0);
        end else if (s_acc && s_op == OP_START && enable_reg && s_source_rate != '0) begin
            div_start = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        enable_next   = enable_reg;
        lvol_next     = lvol_reg;
        rvol_next     = rvol_reg;
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        rep_next      = rep_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;
        left_next     = left_reg;
        active_next   = active_reg;
        mono_next     = mono_reg;
        stereo_next   = stereo_reg;
        samples_next  = samples_reg;
        len_next      = len_reg;
        word_next     = word_reg;
        lastval_next  = lastval_reg;
        pos_next      = pos_reg;
        reading_next  = reading_reg;
        fill_rep_next = fill_rep_reg;
        mv_next       = mv_reg;
        ml_next       = ml_reg;
        mr_next       = mr_reg;
        mlast_next    = mlast_reg;
        ring_we       = 1'b0;
        ring_re       = 1'b0;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_ENABLE:       enable_next = cfg_data[0];
                REG_LEFT_VOLUME:  lvol_next   = cfg_data;
                REG_RIGHT_VOLUME: rvol_next   = cfg_data;
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_op)
                        OP_START: begin
                            if (enable_reg) begin
                                rep_next     = REPEAT_START;
                                samples_next = s_block_samples;
                                stereo_next  = s_stereo;
                                if (s_source_rate != '0) state_next = ST_DIVL;
                            end
                        end
                        OP_SAMPLE: begin
                            word_next = {(mono_reg ? s_left_sample : s_right_sample),
                                         s_left_sample};
                            if (enable_reg && active_reg) begin
                                if (phase_reg >= PHASE_ONE) phase_next = phase_reg - PHASE_ONE;
                                state_next = ST_WR;
                            end
                        end
                        OP_MIX: begin
                            pos_next     = '0;
                            reading_next = 1'b1;
                            lastval_next = '0;
                            state_next   = ST_MSEL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIVL: begin
                if (div_done) begin
                    len_next   = len_sat;
                    state_next = (len_sat == '0) ? ST_IDLE : ST_DIVS;
                end
            end
            ST_DIVS: begin
                if (div_done) begin
                    step_next   = div_q;
                    phase_next  = PHASE_ONE;
                    left_next   = len_reg;
                    active_next = 1'b1;
                    mono_next   = !stereo_reg;
                    state_next  = ST_IDLE;
                end
            end
            ST_WR: begin
                if (active_reg && phase_reg < PHASE_ONE) begin
                    ring_we   = 1'b1;
                    left_next = left_dec;
                    if (wr_inc == rd_reg) begin
                        wr_next     = (rd_reg == '0) ? LAST_IDX : rd_reg - 1'b1;
                        active_next = 1'b0;
                        state_next  = ST_IDLE;
                    end else begin
                        wr_next    = wr_inc;
                        phase_next = phase_reg + step_reg;
                        if (left_dec == '0) active_next = 1'b0;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MSEL: begin
                priority if (reading_reg && pos_reg != FRAME_W'(FRAME_SAMPLES)
                             && rd_reg != wr_reg) begin
                    ring_re    = 1'b1;
                    rd_next    = (rd_reg == LAST_IDX) ? '0 : rd_reg + 1'b1;
                    state_next = ST_MRD;
                end else if (reading_reg) begin
                    reading_next  = 1'b0;
                    fill_rep_next = (rd_reg == wr_reg) && (rep_reg != '0);
                    if ((rd_reg == wr_reg) && (rep_reg != '0)) rep_next = rep_reg - 1'b1;
                end else if (pos_reg == FRAME_W'(FRAME_SAMPLES)) begin
                    state_next = ST_IDLE;
                end else begin
                    word_next  = fill_rep_reg ? lastval_reg : '0;
                    state_next = ST_MEMIT;
                end
            end
            ST_MRD: begin
                word_next    = rdata_reg;
                lastval_next = rdata_reg;
                state_next   = ST_MEMIT;
            end
            ST_MEMIT: begin
                ml_next    = scale_half(word_reg[15:0], lvol_reg);
                mr_next    = scale_half(word_reg[31:16], rvol_reg);
                mlast_next = (pos_reg == FRAME_W'(FRAME_SAMPLES - 1));
                mv_next    = 1'b1;
                state_next = ST_MHOLD;
            end
            ST_MHOLD: begin
                if (m_ready) begin
                    mv_next    = 1'b0;
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_MSEL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ring_we) ring[wr_reg] <= word_reg;
        if (ring_re) rdata_reg <= ring[rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            enable_reg  <= 1'b0;
            lvol_reg    <= 15'd32767;
            rvol_reg    <= 15'd32767;
            wr_reg      <= '0;
            rd_reg      <= '0;
            rep_reg     <= '0;
            phase_reg   <= PHASE_ONE;
            step_reg    <= '0;
            left_reg    <= '0;
            active_reg  <= 1'b0;
            mono_reg    <= 1'b0;
            mv_reg      <= 1'b0;
            reading_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            enable_reg  <= enable_next;
            lvol_reg    <= lvol_next;
            rvol_reg    <= rvol_next;
            wr_reg      <= wr_next;
            rd_reg      <= rd_next;
            rep_reg     <= rep_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            left_reg    <= left_next;
            active_reg  <= active_next;
            mono_reg    <= mono_next;
            mv_reg      <= mv_next;
            reading_reg <= reading_next;
        end
        stereo_reg   <= stereo_next;
        samples_reg  <= samples_next;
        len_reg      <= len_next;
        word_reg     <= word_next;
        lastval_reg  <= lastval_next;
        pos_reg      <= pos_next;
        fill_rep_reg <= fill_rep_next;
        ml_reg       <= ml_next;
        mr_reg       <= mr_next;
        mlast_reg    <= mlast_next;
    end

    assign m_valid     = mv_reg;
    assign m_left_add  = ml_reg;
    assign m_right_add = mr_reg;
    assign m_last      = mlast_reg;

endmodule

// File: rtl/xarr_checker.sv
// ----------------------------------------------------------------------------
// xarr_checker
// Port-level checks on the resampler and mixer handshakes.
// ----------------------------------------------------------------------------
module xarr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_op,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_left_add,
    input logic [15:0] m_right_add,
    input logic        m_last
);
    import xarr_pkg::*;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("result shown while input ready");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_add)
            && $stable(m_right_add) && $stable(m_last))
        else $error("stalled result changed");

    a_quiet_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op != OP_MIX |=> !m_valid)
        else $error("result from non-mix item");

    a_frame_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready)
        else $error("frame ended early");

endmodule

bind xa_audio_ring_resample_mix_core xarr_checker u_xarr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_left_add  (m_left_add),
    .m_right_add (m_right_add),
    .m_last      (m_last)
);

// File: dv/tb_xa_audio_ring_resample_mix_core.sv
// ----------------------------------------------------------------------------
// tb_xa_audio_ring_resample_mix_core
// Self-checking bench for the audio ring resampler and mixer. A mixer
// predictor follows every accepted item and queues the expected frame
// results. Directed items cover the field extremes, zero and saturated
// lengths, mono and stereo blocks and a full ring. Random item sequences run
// under several volume settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_xa_audio_ring_resample_mix_core;
    import xarr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] left_add;
        logic [15:0] right_add;
        logic        last;
    } mix_result_t;

    class mix_scoreboard;
        logic [31:0] ring [RING_DEPTH];
        int unsigned wr_ptr, rd_ptr, repeats, phase, step, remaining;
        bit          active, mono;
        bit          en;
        logic [14:0] lvol, rvol;
        mix_result_t pending[$];
        int          errors;

        function new();
            wr_ptr = 0; rd_ptr = 0; repeats = 0; phase = PHASE_ONE; step = 0;
            remaining = 0; active = 0; mono = 0; en = 0;
            lvol = 15'h7FFF; rvol = 15'h7FFF; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [14:0] data);
            if (idx == REG_ENABLE) en = data[0];
            else if (idx == REG_LEFT_VOLUME) lvol = data;
            else if (idx == REG_RIGHT_VOLUME) rvol = data;
        endfunction

        function logic [15:0] gain(logic [15:0] half, logic [14:0] vol);
            int v;
            v = ($signed(half) * int'(vol)) / 32768;
            return v[15:0];
        endfunction

        function int unsigned bump(int unsigned i);
            return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
        endfunction

        function void push_word(logic [31:0] w, int k);
            mix_result_t r;
            r.left_add  = gain(w[15:0], lvol);
            r.right_add = gain(w[31:16], rvol);
            r.last      = (k == FRAME_SAMPLES - 1);
            pending.push_back(r);
        endfunction

        function void note(logic [1:0] op, logic [11:0] bs, logic [15:0] rate, logic st,
                           logic [15:0] ls, logic [15:0] rs);
            longint unsigned len;
            logic [31:0] w, lastw;
            int k;
            if (op == OP_START) begin
                if (!en) return;
                repeats = REPEAT_START;
                if (rate == 0) return;
                len = (longint'(OUT_RATE) * bs) / rate;
                if (len > LEN_MAX) len = LEN_MAX;
                if (len == 0) return;
                step = (int'(bs) << 16) / int'(len);
                phase = PHASE_ONE;
                remaining = 32'(len);
                active = 1;
                mono = !st;
            end else if (op == OP_SAMPLE) begin
                w = {mono ? ls : rs, ls};
                if (!en || !active) return;
                if (phase >= PHASE_ONE) phase -= PHASE_ONE;
                while (active && phase < PHASE_ONE) begin
                    ring[wr_ptr] = w;
                    wr_ptr = bump(wr_ptr);
                    remaining = (remaining - 1) & LEN_MAX;
                    if (wr_ptr == rd_ptr) begin
                        wr_ptr = (rd_ptr == 0) ? RING_DEPTH - 1 : rd_ptr - 1;
                        active = 0;
                        break;
                    end
                    phase += step;
                    if (remaining == 0) active = 0;
                end
            end else if (op == OP_MIX) begin
                k = 0;
                lastw = 0;
                while (k < FRAME_SAMPLES && rd_ptr != wr_ptr) begin
                    lastw = ring[rd_ptr];
                    rd_ptr = bump(rd_ptr);
                    push_word(lastw, k);
                    k++;
                end
                if (rd_ptr == wr_ptr && repeats != 0) begin
                    repeats--;
                    for (; k < FRAME_SAMPLES; k++) push_word(lastw, k);
                end
                for (; k < FRAME_SAMPLES; k++) push_word(32'h0, k);
            end
        endfunction

        function void check(logic [15:0] l, logic [15:0] r, logic lst);
            mix_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result left_add %0d right_add %0d", $signed(l), $signed(r));
                errors++;
                return;
            end
            e = pending.pop_front();
            if (l !== e.left_add) begin
                $error("left_add expected %0d actual %0d", $signed(e.left_add), $signed(l));
                errors++;
            end
            if (r !== e.right_add) begin
                $error("right_add expected %0d actual %0d", $signed(e.right_add), $signed(r));
                errors++;
            end
            if (lst !== e.last) begin
                $error("last expected %0d actual %0d", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        s_valid, s_ready;
    logic [1:0]  s_op;
    logic [11:0] s_block_samples;
    logic [15:0] s_source_rate;
    logic        s_stereo;
    logic signed [15:0] s_left_sample, s_right_sample;
    logic        m_valid, m_ready;
    logic signed [15:0] m_left_add, m_right_add;
    logic        m_last;

    mix_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_recv = 0;
    bit  hold_go = 0;

    xa_audio_ring_resample_mix_core dut (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_left_add, m_right_add, m_last);
    end

    initial begin
        wait (hold_go);
        hold_recv <= 1'b1;
        repeat (3000) @(posedge aclk);
        hold_recv <= 1'b0;
    end

    task automatic cfg_write(logic [1:0] idx, logic [14:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic send(logic [1:0] op, logic [11:0] bs, logic [15:0] rate, logic st,
                        logic [15:0] ls, logic [15:0] rs);
        s_valid <= 1'b1;
        s_op <= op;
        s_block_samples <= bs;
        s_source_rate <= rate;
        s_stereo <= st;
        s_left_sample <= ls;
        s_right_sample <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note(op, bs, rate, st, ls, rs);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0 || !s_ready) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic rand_items(int n);
        int r;
        logic [11:0] bs;
        logic [15:0] rate;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                bs = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(24));
                rate = ($urandom_range(19) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(11025, 48000));
                send(OP_START, bs, rate, 1'($urandom), 16'($urandom), 16'($urandom));
            end else if (r < 62) begin
                send(OP_SAMPLE, 12'($urandom), 16'($urandom), 1'($urandom),
                     pick_sample(), pick_sample());
            end else if (r < 96) begin
                send(OP_MIX, 12'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom));
            end else begin
                send(OP_UNUSED, 12'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_op = '0; s_block_samples = '0; s_source_rate = '0;
        s_stereo = 1'b0; s_left_sample = '0; s_right_sample = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unit closed: start and sample are dropped, mix gives silence
        send(OP_START, 12'd8, 16'd11025, 1'b1, 16'h0, 16'h0);
        send(OP_SAMPLE, 12'd0, 16'd0, 1'b0, 16'h7FFF, 16'h8000);
        send(OP_MIX, 12'd0, 16'd0, 1'b0, 16'h0, 16'h0);
        drain();
        cfg_write(REG_ENABLE, 15'd1);
        cfg_write(REG_LEFT_VOLUME, 15'h7FFF);
        cfg_write(REG_RIGHT_VOLUME, 15'h7FFF);

        send(OP_SAMPLE, 12'd0, 16'd0, 1'b0, 16'h1234, 16'h4321);
        send(OP_START, 12'd0, 16'd48000, 1'b1, 16'h0, 16'h0);
        send(OP_START, 12'd5, 16'd0, 1'b1, 16'h0, 16'h0);
        send(OP_START, 12'd6, 16'd48000, 1'b1, 16'h0, 16'h0);
        send(OP_SAMPLE, 12'd0, 16'd0, 1'b0, 16'h7FFF, 16'h8000);
        send(OP_SAMPLE, 12'd0, 16'd0, 1'b0, 16'h8000, 16'h7FFF);
        send(OP_START, 12'd3, 16'd11025, 1'b0, 16'h0, 16'h0);
        send(OP_SAMPLE, 12'd0, 16'd0, 1'b1, 16'h8000, 16'h1111);
        send(OP_SAMPLE, 12'd0, 16'd0, 1'b1, 16'hFFFF, 16'h2222);
        send(OP_UNUSED, 12'hFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        send(OP_MIX, 12'd0, 16'd0, 1'b0, 16'h0, 16'h0);
        send(OP_MIX, 12'd0, 16'd0, 1'b0, 16'h0, 16'h0);
        send(OP_START, 12'd4095, 16'd1, 1'b1, 16'h0, 16'h0);
        for (int i = 0; i < 3; i++)
            send(OP_SAMPLE, 12'd0, 16'd0, 1'b0, 16'h7FFF, 16'h8001);
        send(OP_START, 12'd4095, 16'd48000, 1'b1, 16'h0, 16'h0);
        send(OP_SAMPLE, 12'd0, 16'd0, 1'b0, 16'h0001, 16'hFFFE);
        drain();

        // empty the ring
        while (sb.rd_ptr != sb.wr_ptr) send(OP_MIX, 12'd0, 16'd0, 1'b0, 16'h0, 16'h0);
        drain();

        send_idle_pct = 11; recv_idle_pct = 71;
        cfg_write(REG_LEFT_VOLUME, 15'd0);
        cfg_write(REG_RIGHT_VOLUME, 15'd1);
        rand_items(55);
        drain();
        cfg_write(REG_LEFT_VOLUME, 15'($urandom));
        cfg_write(REG_RIGHT_VOLUME, 15'($urandom));
        rand_items(55);
        drain();

        send_idle_pct = 71; recv_idle_pct = 11;
        cfg_write(REG_LEFT_VOLUME, 15'h4000);
        cfg_write(REG_RIGHT_VOLUME, 15'h7FFF);
        rand_items(55);
        drain();
        cfg_write(REG_ENABLE, 15'd0);
        rand_items(25);
        drain();
        cfg_write(REG_ENABLE, 15'd1);

        send_idle_pct = 0; recv_idle_pct = 0;
        cfg_write(REG_LEFT_VOLUME, 15'($urandom));
        cfg_write(REG_RIGHT_VOLUME, 15'($urandom));
        hold_go = 1'b1;
        rand_items(65);
        drain();
        cfg_write(REG_LEFT_VOLUME, 15'h7FFF);
        cfg_write(REG_RIGHT_VOLUME, 15'd0);
        rand_items(55);
        drain();

        // fill the ring with a long slow block, then bounce off the full ring
        send(OP_START, 12'd4095, 16'd1, 1'b1, 16'h0, 16'h0);
        while (sb.active)
            send(OP_SAMPLE, 12'd0, 16'd0, 1'b0, 16'($urandom), 16'($urandom));
        send(OP_START, 12'd4095, 16'd11025, 1'b0, 16'h0, 16'h0);
        for (int i = 0; i < 3; i++)
            send(OP_SAMPLE, 12'd0, 16'd0, 1'b0, 16'($urandom), 16'($urandom));
        for (int i = 0; i < 4; i++)
            send(OP_MIX, 12'd0, 16'd0, 1'b0, 16'h0, 16'h0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.pending.size() != 0)
                $error("%0d expected results never arrived", sb.pending.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
